// ===== hdl/pnrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrs_pkg
// Shared constants, control word layout and microprogram of the
// nearest-object ring search over a color-ID picking image.
// ----------------------------------------------------------------------------
package pnrs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int VW         = (XW > YW) ? XW : YW;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam int RGB_W  = 24;
    localparam int POS_W  = 16;
    localparam int CFG_W  = 9;
    localparam int CFG_AW = 2;
    localparam int RAD_W  = 4;

    localparam logic [RGB_W-1:0] WHITE_RGB    = {3{8'd255}};
    localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd10;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SEARCH_RADIUS = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_QINIT  = 4'd1,
        ST_CENTER = 4'd2,
        ST_RING   = 4'd3,
        ST_TOP    = 4'd4,
        ST_BOT    = 4'd5,
        ST_LEFT   = 4'd6,
        ST_RIGHT  = 4'd7,
        ST_NONE   = 4'd8,
        ST_WRITE  = 4'd9,
        ST_OUT    = 4'd10
    } step_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_IDLE,
        C_OUTSIDE,
        C_RADIUS,
        C_SCAN,
        C_OUT
    } cond_t;

    typedef enum logic [1:0] { COL_PX, COL_CX, COL_CXMD, COL_CXPD } col_t;
    typedef enum logic [1:0] { ROW_PY, ROW_CY, ROW_CYMD, ROW_CYPD } row_t;
    typedef enum logic [1:0] { VL_HOLD, VL_CXMD, VL_CYMD, VL_CXMD1 } vload_t;
    typedef enum logic { END_CX, END_CY } ends_t;

    typedef struct packed {
        cond_t  cond;
        step_t  target;
        logic   rd;
        logic   chk;
        logic   wr;
        logic   init;
        logic   dinc;
        logic   col_v;
        logic   row_v;
        col_t   col;
        row_t   row;
        vload_t vload;
        ends_t  ends;
        logic   res_clr;
        logic   emit;
    } ctl_t;

    function automatic ctl_t ucode(step_t s);
        ctl_t c;
        c = '{cond: C_JUMP, target: ST_IDLE, rd: 1'b0, chk: 1'b0, wr: 1'b0,
              init: 1'b0, dinc: 1'b0, col_v: 1'b0, row_v: 1'b0, col: COL_PX,
              row: ROW_PY, vload: VL_HOLD, ends: END_CX, res_clr: 1'b0,
              emit: 1'b0};
        unique case (s)
            ST_IDLE: begin
                c.cond = C_IDLE; c.target = ST_WRITE;
            end
            ST_QINIT: begin
                c.cond = C_OUTSIDE; c.target = ST_NONE; c.init = 1'b1;
            end
            ST_CENTER: begin
                c.cond = C_NEXT; c.rd = 1'b1; c.col = COL_CX; c.row = ROW_CY;
            end
            ST_RING: begin
                c.cond = C_RADIUS; c.target = ST_NONE; c.chk = 1'b1;
                c.dinc = 1'b1; c.vload = VL_CXMD1;
            end
            ST_TOP: begin
                c.cond = C_SCAN; c.target = ST_BOT; c.chk = 1'b1; c.rd = 1'b1;
                c.col_v = 1'b1; c.row = ROW_CYMD; c.vload = VL_CXMD; c.ends = END_CX;
            end
            ST_BOT: begin
                c.cond = C_SCAN; c.target = ST_LEFT; c.chk = 1'b1; c.rd = 1'b1;
                c.col_v = 1'b1; c.row = ROW_CYPD; c.vload = VL_CYMD; c.ends = END_CX;
            end
            ST_LEFT: begin
                c.cond = C_SCAN; c.target = ST_RIGHT; c.chk = 1'b1; c.rd = 1'b1;
                c.row_v = 1'b1; c.col = COL_CXMD; c.vload = VL_CYMD; c.ends = END_CY;
            end
            ST_RIGHT: begin
                c.cond = C_SCAN; c.target = ST_RING; c.chk = 1'b1; c.rd = 1'b1;
                c.row_v = 1'b1; c.col = COL_CXPD; c.vload = VL_CYMD; c.ends = END_CY;
            end
            ST_NONE: begin
                c.cond = C_JUMP; c.target = ST_OUT; c.res_clr = 1'b1;
            end
            ST_WRITE: begin
                c.cond = C_JUMP; c.target = ST_OUT; c.res_clr = 1'b1; c.wr = 1'b1;
            end
            ST_OUT: begin
                c.cond = C_OUT; c.target = ST_IDLE; c.emit = 1'b1;
            end
            default: begin
                c.cond = C_JUMP; c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/pnrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnrs_ram
// Generic single-port RAM, one address per cycle, read every cycle with an optional write; registered read data.
// ----------------------------------------------------------------------------
module pnrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/pick_nearest_ring_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pick_nearest_ring_search
// Color-ID picking image with nearest non-white pixel search in square rings.
// ----------------------------------------------------------------------------
//  channel   ports                                        dir
//  request   s_valid s_ready s_func s_pos_x s_pos_y         in
//            s_pixel_rgb
//  result    m_valid m_ready m_found m_object_rgb m_changed  out
//  config    cfg_we cfg_addr cfg_wdata                       in
//
//  A write goes from accept through the write step to the output step; a query
//  through init, center and, per ring d, the top, bottom, left and right scans.
//  The pixel RAM port reads one pixel a cycle. One request is worked at a time;
//  a new one is accepted while the previous result waits on m_ready.
//  Reset clears control state only; the pixel RAM is not cleared.
// ----------------------------------------------------------------------------
module pick_nearest_ring_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pnrs_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [pnrs_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic signed [pnrs_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [pnrs_pkg::POS_W-1:0] s_pos_y,
    input  logic [pnrs_pkg::RGB_W-1:0]    s_pixel_rgb,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [pnrs_pkg::RGB_W-1:0]    m_object_rgb,
    output logic                          m_changed
);
    import pnrs_pkg::*;

    step_t pc_reg, pc_next;
    ctl_t  ctl;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [RAD_W-1:0] radius_reg;

    logic             func_reg;
    logic [POS_W-1:0] px_reg, py_reg;
    logic [RGB_W-1:0] rgb_reg;

    logic [XW-1:0]    cx_reg;
    logic [YW-1:0]    cy_reg;
    logic [RAD_W-1:0] rad_reg, d_reg;
    logic [VW-1:0]    v_reg, v_next;
    logic             pend_reg;

    logic             res_found_reg;
    logic [RGB_W-1:0] res_rgb_reg;
    logic             last_found_reg;
    logic [RGB_W-1:0] last_rgb_reg;

    logic             m_valid_reg, m_found_reg, m_changed_reg;
    logic [RGB_W-1:0] m_rgb_reg;

    logic [POS_W-1:0] eff_w, eff_h, lim;
    logic             in_image, hit, scan_end, accept, out_free;
    logic [XW-1:0]    col;
    logic [YW-1:0]    row;
    logic [ADDR_W-1:0] ram_addr;
    logic [RGB_W-1:0]  ram_rdata;
    logic [RAD_W-1:0]  d_inc;

    assign ctl      = ucode(pc_reg);
    assign s_ready  = (pc_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = ctl.chk && pend_reg && (ram_rdata != WHITE_RGB);
    assign d_inc    = d_reg + 1'b1;

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_object_rgb = m_rgb_reg;
    assign m_changed    = m_changed_reg;

    always_comb begin
        eff_w = (POS_W'(width_reg) > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH)
                                                          : POS_W'(width_reg);
        eff_h = (POS_W'(height_reg) > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT)
                                                            : POS_W'(height_reg);
        in_image = !px_reg[POS_W-1] && !py_reg[POS_W-1] &&
                   (px_reg < eff_w) && (py_reg < eff_h);
        lim = POS_W'(radius_reg);
        if (px_reg < lim) begin
            lim = px_reg;
        end
        if (eff_w - 1'b1 - px_reg < lim) begin
            lim = eff_w - 1'b1 - px_reg;
        end
        if (py_reg < lim) begin
            lim = py_reg;
        end
        if (eff_h - 1'b1 - py_reg < lim) begin
            lim = eff_h - 1'b1 - py_reg;
        end
    end

    always_comb begin
        case (ctl.col)
            COL_PX:   col = px_reg[XW-1:0];
            COL_CX:   col = cx_reg;
            COL_CXMD: col = cx_reg - XW'(d_reg);
            COL_CXPD: col = cx_reg + XW'(d_reg);
            default:  col = cx_reg;
        endcase
        if (ctl.col_v) begin
            col = v_reg[XW-1:0];
        end
        case (ctl.row)
            ROW_PY:   row = py_reg[YW-1:0];
            ROW_CY:   row = cy_reg;
            ROW_CYMD: row = cy_reg - YW'(d_reg);
            ROW_CYPD: row = cy_reg + YW'(d_reg);
            default:  row = cy_reg;
        endcase
        if (ctl.row_v) begin
            row = v_reg[YW-1:0];
        end
        ram_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
    end

    always_comb begin
        if (ctl.ends == END_CX) begin
            scan_end = (v_reg == VW'(cx_reg) + VW'(d_reg));
        end else begin
            scan_end = (v_reg == VW'(cy_reg) + VW'(d_reg));
        end

        v_next = v_reg;
        if (ctl.cond == C_SCAN && !scan_end) begin
            v_next = v_reg + 1'b1;
        end else begin
            case (ctl.vload)
                VL_HOLD:  v_next = v_reg;
                VL_CXMD:  v_next = VW'(cx_reg) - VW'(d_reg);
                VL_CYMD:  v_next = VW'(cy_reg) - VW'(d_reg);
                VL_CXMD1: v_next = VW'(cx_reg) - VW'(d_inc);
                default:  v_next = v_reg;
            endcase
        end

        case (ctl.cond)
            C_NEXT:    pc_next = step_t'(4'(pc_reg) + 4'd1);
            C_JUMP:    pc_next = ctl.target;
            C_IDLE: begin
                if (!accept) begin
                    pc_next = pc_reg;
                end else if (s_func == FUNC_WRITE) begin
                    pc_next = ctl.target;
                end else begin
                    pc_next = step_t'(4'(pc_reg) + 4'd1);
                end
            end
            C_OUTSIDE: pc_next = in_image ? step_t'(4'(pc_reg) + 4'd1) : ctl.target;
            C_RADIUS:  pc_next = (d_reg == rad_reg) ? ctl.target
                                                    : step_t'(4'(pc_reg) + 4'd1);
            C_SCAN:    pc_next = scan_end ? ctl.target : pc_reg;
            C_OUT:     pc_next = out_free ? ctl.target : pc_reg;
            default:   pc_next = ST_IDLE;
        endcase
        if (hit) begin
            pc_next = ST_OUT;
        end
    end

    pnrs_ram #(
        .WIDTH (RGB_W),
        .DEPTH (DEPTH)
    ) u_pixels (
        .aclk  (aclk),
        .we    (ctl.wr && in_image),
        .addr  (ram_addr),
        .wdata (rgb_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= ST_IDLE;
            width_reg      <= '0;
            height_reg     <= '0;
            radius_reg     <= RADIUS_RESET;
            pend_reg       <= 1'b0;
            last_found_reg <= 1'b0;
            last_rgb_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            pend_reg <= ctl.rd;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_wdata;
                    REG_SEARCH_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (ctl.emit && out_free) begin
                m_valid_reg <= 1'b1;
                if (func_reg == FUNC_QUERY) begin
                    last_found_reg <= res_found_reg;
                    last_rgb_reg   <= res_rgb_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            px_reg   <= s_pos_x;
            py_reg   <= s_pos_y;
            rgb_reg  <= s_pixel_rgb;
        end
        if (ctl.init) begin
            cx_reg  <= px_reg[XW-1:0];
            cy_reg  <= py_reg[YW-1:0];
            rad_reg <= lim[RAD_W-1:0];
            d_reg   <= '0;
        end else if (ctl.dinc) begin
            d_reg <= d_inc;
        end
        v_reg <= v_next;
        if (hit) begin
            res_found_reg <= 1'b1;
            res_rgb_reg   <= ram_rdata;
        end else if (ctl.res_clr) begin
            res_found_reg <= 1'b0;
            res_rgb_reg   <= '0;
        end
        if (ctl.emit && out_free) begin
            m_found_reg   <= res_found_reg;
            m_rgb_reg     <= res_rgb_reg;
            m_changed_reg <= (func_reg == FUNC_QUERY) &&
                             ((res_found_reg != last_found_reg) ||
                              (res_rgb_reg != last_rgb_reg));
        end
    end

endmodule

// ===== tb/pick_nearest_ring_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pick_nearest_ring_search_tb
// Self-checking bench for the nearest-object ring search. Pixel writes and
// queries go in over the request channel. A scoreboard keeps its own copy of
// the picking image and the last answer, predicts every result and checks it
// field by field. Before a query is sent, every pixel that the query would
// read is written first. Random phases vary the image size, the search
// radius, the share of background pixels and the idling on both channels.
// ----------------------------------------------------------------------------
module pick_nearest_ring_search_tb;
    import pnrs_pkg::*;

    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 62;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;

    localparam int PHASE_W [PHASES]     = '{256, 16, 1, 511, 0, 37, 256, 8, 255, 64};
    localparam int PHASE_H [PHASES]     = '{256, 16, 256, 200, 16, 1, 3, 8, 255, 0};
    localparam int PHASE_R [PHASES]     = '{15, 10, 0, 15, 3, 7, 15, 12, 1, 5};
    localparam int PHASE_WHITE [PHASES] = '{95, 80, 90, 97, 60, 100, 95, 100, 85, 70};

    typedef enum int { SCAN_NONE, SCAN_HIT, SCAN_GAP } scan_t;

    typedef struct packed {
        logic             found;
        logic [RGB_W-1:0] rgb;
        logic             changed;
    } pick_t;

    class pick_checker;
        logic [RGB_W-1:0] image [DEPTH];
        bit               written [DEPTH];
        int               width_reg;
        int               height_reg;
        int               radius_reg;
        logic             last_found;
        logic [RGB_W-1:0] last_rgb;
        pick_t            expected_picks [$];
        int               mismatches;

        function new();
            width_reg  = 0;
            height_reg = 0;
            radius_reg = RADIUS_RESET;
            last_found = 1'b0;
            last_rgb   = '0;
            mismatches = 0;
        endfunction

        function void apply_register(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:   width_reg  = value;
                REG_IMAGE_HEIGHT:  height_reg = value;
                REG_SEARCH_RADIUS: radius_reg = value[RAD_W-1:0];
                default: ;
            endcase
        endfunction

        function int used_width();
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int used_height();
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        function bit on_image(int x, int y);
            return x >= 0 && y >= 0 && x < used_width() && y < used_height();
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // Walk the rings in read order; stop at the first non-white pixel or
        // at the first pixel not yet written.
        function scan_t ring_search(int x, int y, output logic [RGB_W-1:0] hit,
                                    output int gap_x, output int gap_y);
            int reach;
            int d;
            int side;
            int v;
            int px;
            int py;
            hit   = '0;
            gap_x = 0;
            gap_y = 0;
            if (!on_image(x, y))
                return SCAN_NONE;
            reach = radius_reg;
            if (x < reach) reach = x;
            if (used_width() - 1 - x < reach) reach = used_width() - 1 - x;
            if (y < reach) reach = y;
            if (used_height() - 1 - y < reach) reach = used_height() - 1 - y;
            for (d = 0; d <= reach; d++) begin
                for (side = 0; side < 4; side++) begin
                    for (v = -d; v <= d; v++) begin
                        if (d == 0 && side != 0)
                            continue;
                        case (side)
                            0: begin px = x + v; py = y - d; end
                            1: begin px = x + v; py = y + d; end
                            2: begin px = x - d; py = y + v; end
                            default: begin px = x + d; py = y + v; end
                        endcase
                        if (!written[py * MAX_WIDTH + px]) begin
                            gap_x = px;
                            gap_y = py;
                            return SCAN_GAP;
                        end
                        if (image[py * MAX_WIDTH + px] != WHITE_RGB) begin
                            hit = image[py * MAX_WIDTH + px];
                            return SCAN_HIT;
                        end
                    end
                end
            end
            return SCAN_NONE;
        endfunction

        task report_mismatch(string what, longint want_v, longint got_v);
            $display("%0t mismatch: %s expected %0h got %0h", $time, what, want_v, got_v);
            mismatches++;
        endtask

        task note_request(logic func, int x, int y, logic [RGB_W-1:0] rgb);
            pick_t            want;
            logic [RGB_W-1:0] hit;
            int               gx;
            int               gy;
            scan_t            outcome;
            want = '0;
            if (func == FUNC_WRITE) begin
                if (on_image(x, y)) begin
                    image[y * MAX_WIDTH + x]   = rgb;
                    written[y * MAX_WIDTH + x] = 1'b1;
                end
            end else begin
                outcome = ring_search(x, y, hit, gx, gy);
                if (outcome == SCAN_GAP)
                    report_mismatch("query reads unwritten pixel at x/y", gx, gy);
                want.found   = (outcome == SCAN_HIT);
                want.rgb     = want.found ? hit : '0;
                want.changed = (want.found != last_found) || (want.rgb != last_rgb);
                last_found   = want.found;
                last_rgb     = want.rgb;
            end
            expected_picks.push_back(want);
        endtask

        task check_result(logic found, logic [RGB_W-1:0] rgb, logic changed);
            pick_t want;
            if (expected_picks.size() == 0) begin
                report_mismatch("result with no request", 0, {found, rgb, changed});
                return;
            end
            want = expected_picks.pop_front();
            if (found !== want.found)
                report_mismatch("found", want.found, found);
            if (rgb !== want.rgb)
                report_mismatch("object_rgb", want.rgb, rgb);
            if (changed !== want.changed)
                report_mismatch("changed", want.changed, changed);
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_AW-1:0]       cfg_addr;
    logic [CFG_W-1:0]        cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_func;
    logic signed [POS_W-1:0] s_pos_x;
    logic signed [POS_W-1:0] s_pos_y;
    logic [RGB_W-1:0]        s_pixel_rgb;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_found;
    logic [RGB_W-1:0]        m_object_rgb;
    logic                    m_changed;

    pick_checker board;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          items_sent         = 0;
    int          idle_cycles        = 0;

    pick_nearest_ring_search dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pixel_rgb  (s_pixel_rgb),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_object_rgb (m_object_rgb),
        .m_changed    (m_changed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_found, m_object_rgb, m_changed);
            if (s_valid && s_ready)
                board.note_request(s_func, s_pos_x, s_pos_y, s_pixel_rgb);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("pick_nearest_ring_search_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [RGB_W-1:0] paint(int white_pct);
        if ($urandom_range(99) < white_pct)
            return WHITE_RGB;
        case ($urandom_range(3))
            0: return '0;
            1: return RGB_W'(WHITE_RGB - 1);
            default: return RGB_W'($urandom());
        endcase
    endfunction

    function automatic int rand_pos();
        logic signed [POS_W-1:0] p;
        p = POS_W'($urandom());
        return p;
    endfunction

    function automatic int pick_zone(int n);
        case ($urandom_range(2))
            0: return 0;
            1: return (n > 16) ? n - 16 : 0;
            default: return $urandom_range(0, (n > 0) ? n - 1 : 0);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_request(logic func, int x, int y, logic [RGB_W-1:0] rgb);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_func      = func;
        s_pos_x     = POS_W'(x);
        s_pos_y     = POS_W'(y);
        s_pixel_rgb = rgb;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    // Fill every pixel the query would read, then send the query.
    task automatic send_query(int x, int y, int white_pct);
        logic [RGB_W-1:0] hit;
        int               gx;
        int               gy;
        while (board.ring_search(x, y, hit, gx, gy) == SCAN_GAP)
            send_request(FUNC_WRITE, gx, gy, paint(white_pct));
        send_request(FUNC_QUERY, x, y, RGB_W'($urandom()));
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_AW-1:0] idx, int value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = CFG_W'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
        board.apply_register(idx, CFG_W'(value));
    endtask

    task automatic set_image(int width, int height, int radius);
        wait_idle();
        write_register(REG_IMAGE_WIDTH, width);
        write_register(REG_IMAGE_HEIGHT, height);
        write_register(REG_SEARCH_RADIUS, radius);
    endtask

    task automatic run_phase(int p);
        int zone_x;
        int zone_y;
        int x;
        int y;
        int pick;
        int start;
        bit held;
        set_image(PHASE_W[p], PHASE_H[p], PHASE_R[p]);
        case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
        endcase
        zone_x = pick_zone(board.used_width());
        zone_y = pick_zone(board.used_height());
        start  = items_sent;
        held   = 1'b0;
        while (items_sent - start < PHASE_ITEMS) begin
            if (!held && items_sent - start >= PHASE_ITEMS / 2) begin
                // hold off until every answer is back
                wait_idle();
                held = 1'b1;
            end
            x    = zone_x - 2 + $urandom_range(0, 19);
            y    = zone_y - 2 + $urandom_range(0, 19);
            pick = $urandom_range(99);
            if (pick < 45)
                send_query(x, y, PHASE_WHITE[p]);
            else if (pick < 75)
                send_request(FUNC_WRITE, x, y, paint(50));
            else if (pick < 87)
                send_request(FUNC_WRITE, rand_pos(), rand_pos(), RGB_W'($urandom()));
            else
                send_query(rand_pos(), rand_pos(), PHASE_WHITE[p]);
        end
    endtask

    initial begin
        board       = new();
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_func      = FUNC_WRITE;
        s_pos_x     = '0;
        s_pos_y     = '0;
        s_pixel_rgb = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // no image configured yet
        send_query(0, 0, 100);
        send_request(FUNC_WRITE, 5, 5, 24'h0000FF);
        wait_idle();
        write_register(REG_IMAGE_WIDTH, 16);
        write_register(REG_IMAGE_HEIGHT, 8);
        send_request(FUNC_WRITE, 3, 3, '0);
        send_query(3, 3, 100);
        send_request(FUNC_WRITE, -32768, 32767, WHITE_RGB);
        send_request(FUNC_WRITE, 16, 0, 24'h123456);
        send_query(-32768, -32768, 100);
        send_query(32767, 7, 100);
        send_query(0, 8, 100);
        send_query(1, 1, 100);
        send_request(FUNC_WRITE, 2, 2, RGB_W'(WHITE_RGB - 1));
        send_request(FUNC_WRITE, 1, 2, 24'h00FF00);
        send_query(1, 1, 100);
        send_request(FUNC_WRITE, 1, 2, WHITE_RGB);
        send_query(1, 1, 100);
        send_query(1, 1, 100);
        send_request(FUNC_WRITE, 2, 0, 24'hABCDEF);
        send_query(1, 1, 100);
        // oversized image, center-only search
        set_image(511, 511, 0);
        send_request(FUNC_WRITE, 255, 255, 24'h5A5A5A);
        send_request(FUNC_WRITE, 256, 0, 24'h0F0F0F);
        send_query(255, 255, 100);
        send_query(256, 255, 100);
        send_query(1, 1, 100);

        for (int p = 0; p < PHASES; p++)
            run_phase(p);

        wait_idle();
        if (board.mismatches == 0)
            $display("pick_nearest_ring_search_tb OK");
        else
            $display("pick_nearest_ring_search_tb NOT OK");
        $finish;
    end
endmodule
